/* hdl/lik_pkg.sv */
// Package for the leg inverse kinematics unit: datapath widths, state and
// mode enums, register indexes and the CORDIC arctangent table.
// No dependencies.
package lik_pkg;

  localparam int RW  = 62;   // iterative unit working width
  localparam int CW  = 44;   // CORDIC x and y width
  localparam int ZW  = 34;   // angle accumulator width, Q30 radians
  localparam int QW  = 31;   // root and quotient width
  localparam int NW  = 6;    // step counter width
  localparam int MW  = 34;   // multiplier operand width
  localparam int IN_W  = 64;
  localparam int OUT_W = 104;

  localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
  localparam logic [28:0] CD_PER_RAD    = 29'd375493621;
  localparam logic [18:0] FOOT_BIAS_CD  = 19'd9000;
  localparam logic [NW-1:0] RATIO_STEPS = NW'(31);
  localparam logic [NW-1:0] ROOT_STEPS  = NW'(31);
  localparam logic [NW-1:0] SPEED_STEPS = NW'(17);

  typedef enum logic [1:0] {
    IT_SQRT,
    IT_DIV,
    IT_CORDIC
  } iter_mode_t;

  typedef struct packed {
    logic            start;
    iter_mode_t      mode;
    logic [NW-1:0]   steps;
  } iter_ctrl_t;

  typedef enum logic [2:0] {
    CFG_ANCHOR_X,
    CFG_ANCHOR_Y,
    CFG_ANCHOR_Z,
    CFG_ANCHOR_ANGLE,
    CFG_HIP_KNEE,
    CFG_THIGH,
    CFG_SHIN
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_DX,
    S_SQ_DY,
    S_P2,
    S_LEN,
    S_SQ_HQ,
    S_SQ_ZQ,
    S_L2,
    S_LQ,
    S_TT,
    S_FF,
    S_TF,
    S_LT,
    S_NUM,
    S_CHK,
    S_HIP,
    S_VA,
    S_DIV_GO,
    S_DIV,
    S_CC,
    S_SQ_GO,
    S_SQ_S,
    S_ACOS,
    S_CD_MUL,
    S_CD_RND,
    S_DIFF,
    S_BIG,
    S_SCALE,
    S_SPD_MUL,
    S_SPD_GO,
    S_SPD_DIV,
    S_FAIL
  } state_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd31: v = 31'd0;
      default: v = 31'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

/* hdl/lik_iter.sv */
// Shared iterative unit: bitwise square root, restoring division and
// vectoring CORDIC, one step per cycle. Depends on lik_pkg.
module lik_iter (
  input  logic                          clk,
  input  logic                          rst,
  input  lik_pkg::iter_ctrl_t           ctrl,
  input  logic [lik_pkg::RW-1:0]        num,
  input  logic [lik_pkg::RW-1:0]        den,
  input  logic signed [lik_pkg::CW-1:0] cx,
  input  logic signed [lik_pkg::CW-1:0] cy,
  output logic                          done,
  output logic [lik_pkg::QW-1:0]        res,
  output logic signed [lik_pkg::ZW-1:0] ang
);
  import lik_pkg::*;

  logic                 busy;
  logic [NW-1:0]        cnt;
  logic [4:0]           idx;
  iter_mode_t           mode;
  logic [RW-1:0]        rem;
  logic [RW-1:0]        acc;
  logic [RW-1:0]        bval;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic                 zero;

  logic [RW-1:0]        sq_t;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] half_pi;

  assign sq_t    = acc + bval;
  assign xs      = x >>> idx;
  assign ys      = y >>> idx;
  assign at      = $signed(ZW'(atan_q30(idx)));
  assign half_pi = $signed(ZW'(HALF_PI_Q30));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode <= ctrl.mode;
      idx  <= '0;
      rem  <= num;
      acc  <= '0;
      bval <= (ctrl.mode == IT_SQRT) ? (RW'(1) << (RW - 2)) : den;
      zero <= (cx == '0) && (cy == '0);
      if (cx < 0) begin
        if (cy >= 0) begin
          x <= cy;
          y <= -cx;
          z <= half_pi;
        end else begin
          x <= -cy;
          y <= cx;
          z <= -half_pi;
        end
      end else begin
        x <= cx;
        y <= cy;
        z <= '0;
      end
    end else if (busy) begin
      idx <= idx + 5'd1;
      unique case (mode)
        IT_SQRT: begin
          if (rem >= sq_t) begin
            rem <= rem - sq_t;
            acc <= (acc >> 1) + bval;
          end else begin
            acc <= acc >> 1;
          end
          bval <= bval >> 2;
        end
        IT_DIV: begin
          if (rem >= bval) begin
            rem <= (rem - bval) << 1;
            acc <= (acc << 1) | RW'(1);
          end else begin
            rem <= rem << 1;
            acc <= acc << 1;
          end
        end
        IT_CORDIC: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign res = acc[QW-1:0];
  assign ang = zero ? '0 : z;

endmodule

/* hdl/leg_inverse_kinematics_unit.sv */
// Leg inverse kinematics unit: sequencer, shared multiplier and result
// register around the iterative unit. Depends on lik_pkg and lik_iter.
//
//  channel  | dir | fields (low bit first)
//  s_*      | in  | tdata: target_x, target_y, target_z, move_speed
//  m_*      | out | tdata: hip, knee, foot angle, hip, knee, foot speed; tuser: ok
//  cfg_*    | in  | index 0..6: anchor x, y, z, angle, hip-knee, thigh, shin
//
// Each word is worked through the states in turn, sharing the single iterative unit;
// the path is shorter on failure or when no angle changes.
// s_tready is high only while idle, so a new word is taken only once the last result is handed over.
// The result is held until m_tready.
// Reset is synchronous and returns the lengths to 30, 80 and 120.
module leg_inverse_kinematics_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lik_pkg::IN_W-1:0]     s_tdata,   // target_x, target_y, target_z, move_speed
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lik_pkg::OUT_W-1:0]    m_tdata,   // hip, knee, foot angle, hip, knee, foot speed
  output logic                         m_tuser,   // ok
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);
  import lik_pkg::*;

  state_t state, state_next;

  logic signed [15:0] anchor_x, anchor_y, anchor_z, anchor_angle;
  logic [11:0]        hip_knee_length, femur_length, shin_length;

  logic signed [16:0] dx, dy, dz;
  logic [15:0]        spd;
  logic [50:0]        sq0;
  logic [50:0]        l2;
  logic [24:0]        hq;
  logic [25:0]        lq;
  logic [23:0]        tt, ff, tf;
  logic [37:0]        lt;
  logic signed [51:0] num_f, num_b;
  logic signed [ZW-1:0] va;
  logic [QW-1:0]      cmag;
  logic               cneg;
  logic               pass;
  logic [1:0]         j;
  logic signed [ZW-1:0] rad [3];
  logic signed [16:0] angv [3];
  logic signed [16:0] last [3];
  logic [16:0]        dif [3];
  logic [16:0]        big;
  logic [15:0]        speed [3];
  logic               ok_r;

  logic [MW-1:0]      mul_a, mul_b;
  logic [2*MW-1:0]    mul_p;

  iter_ctrl_t           ictrl;
  logic [RW-1:0]        inum, iden;
  logic signed [CW-1:0] icx, icy;
  logic                 idone;
  logic [QW-1:0]        ires;
  logic signed [ZW-1:0] iang;

  logic [16:0]        a_dx, a_dy, a_dz;
  logic [33:0]        p2;
  logic [50:0]        l2_sum;
  logic signed [26:0] hq_d;
  logic [51:0]        mag_f, mag_b;
  logic signed [31:0] cval;
  logic [ZW-1:0]      rad_mag;
  logic [2*MW-1:0]    cd_prod;
  logic signed [18:0] cd_s, cd_ofs, cd_v;
  logic signed [17:0] dd [3];
  logic [16:0]        big_c;

  lik_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ictrl),
    .num  (inum),
    .den  (iden),
    .cx   (icx),
    .cy   (icy),
    .done (idone),
    .res  (ires),
    .ang  (iang)
  );

  assign a_dx    = dx[16] ? 17'(-dx) : 17'(dx);
  assign a_dy    = dy[16] ? 17'(-dy) : 17'(dy);
  assign a_dz    = dz[16] ? 17'(-dz) : 17'(dz);
  assign p2      = 34'(sq0) + mul_p[33:0];
  assign l2_sum  = sq0 + mul_p[50:0];
  assign hq_d    = $signed({2'b00, ires[24:0]}) - $signed({7'b0, hip_knee_length, 8'b0});
  assign mag_f   = num_f[51] ? 52'(-num_f) : 52'(num_f);
  assign mag_b   = num_b[51] ? 52'(-num_b) : 52'(num_b);
  assign cval    = cneg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  assign rad_mag = rad[j][ZW-1] ? ZW'(-rad[j]) : ZW'(rad[j]);
  assign cd_prod = mul_p + ((2*MW)'(1) << 45);
  assign cd_s    = rad[j][ZW-1] ? -$signed({1'b0, cd_prod[63:46]})
                                :  $signed({1'b0, cd_prod[63:46]});
  assign cd_ofs  = (j == 2'd0) ? 19'(anchor_angle) :
                   (j == 2'd2) ? $signed(FOOT_BIAS_CD) : 19'sd0;
  assign cd_v    = cd_s - cd_ofs;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k] = $signed({angv[k][16], angv[k]}) - $signed({last[k][16], last[k]});
    end
    big_c = dif[0];
    if (dif[1] > big_c) big_c = dif[1];
    if (dif[2] > big_c) big_c = dif[2];
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x        <= '0;
      anchor_y        <= '0;
      anchor_z        <= '0;
      anchor_angle    <= '0;
      hip_knee_length <= 12'd30;
      femur_length    <= 12'd80;
      shin_length     <= 12'd120;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANCHOR_X:     anchor_x        <= cfg_data;
        CFG_ANCHOR_Y:     anchor_y        <= cfg_data;
        CFG_ANCHOR_Z:     anchor_z        <= cfg_data;
        CFG_ANCHOR_ANGLE: anchor_angle    <= cfg_data;
        CFG_HIP_KNEE:     hip_knee_length <= cfg_data[11:0];
        CFG_THIGH:        femur_length    <= cfg_data[11:0];
        CFG_SHIN:         shin_length     <= cfg_data[11:0];
        default:          anchor_x        <= anchor_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        last[k] <= '0;
      end
    end else if (state == S_BIG) begin
      for (int k = 0; k < 3; k++) begin
        last[k] <= angv[k];
      end
    end
  end

  always_comb begin
    state_next  = state;
    ictrl.start = 1'b0;
    ictrl.mode  = IT_SQRT;
    ictrl.steps = ROOT_STEPS;
    inum        = '0;
    iden        = '0;
    icx         = '0;
    icy         = '0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = S_SQ_DX;
      S_SQ_DX: begin
        mul_a      = MW'(a_dx);
        mul_b      = MW'(a_dx);
        state_next = S_SQ_DY;
      end
      S_SQ_DY: begin
        mul_a      = MW'(a_dy);
        mul_b      = MW'(a_dy);
        state_next = S_P2;
      end
      S_P2: begin
        if (femur_length == '0 || shin_length == '0 || p2 == '0) begin
          state_next = S_FAIL;
        end else begin
          ictrl.start = 1'b1;
          inum        = RW'(p2) << 16;
          state_next  = S_LEN;
        end
      end
      S_LEN:     if (idone) state_next = S_SQ_HQ;
      S_SQ_HQ: begin
        mul_a      = MW'(hq);
        mul_b      = MW'(hq);
        state_next = S_SQ_ZQ;
      end
      S_SQ_ZQ: begin
        mul_a      = MW'({a_dz, 8'b0});
        mul_b      = MW'({a_dz, 8'b0});
        state_next = S_L2;
      end
      S_L2: begin
        if (l2_sum == '0) begin
          state_next = S_FAIL;
        end else begin
          ictrl.start = 1'b1;
          inum        = RW'(l2_sum);
          state_next  = S_LQ;
        end
      end
      S_LQ:      if (idone) state_next = S_TT;
      S_TT: begin
        mul_a      = MW'(femur_length);
        mul_b      = MW'(femur_length);
        state_next = S_FF;
      end
      S_FF: begin
        mul_a      = MW'(shin_length);
        mul_b      = MW'(shin_length);
        state_next = S_TF;
      end
      S_TF: begin
        mul_a      = MW'(femur_length);
        mul_b      = MW'(shin_length);
        state_next = S_LT;
      end
      S_LT: begin
        mul_a      = MW'(lq);
        mul_b      = MW'(femur_length);
        state_next = S_NUM;
      end
      S_NUM:     state_next = S_CHK;
      S_CHK: begin
        if (mag_f > 52'({tf, 17'b0}) || mag_b > 52'({lt, 9'b0})) begin
          state_next = S_FAIL;
        end else begin
          ictrl.start = 1'b1;
          ictrl.mode  = IT_CORDIC;
          ictrl.steps = NW'(CORDIC_STEPS);
          icx         = {{3{dx[16]}}, dx, 24'b0};
          icy         = {{3{dy[16]}}, dy, 24'b0};
          state_next  = S_HIP;
        end
      end
      S_HIP: begin
        if (idone) begin
          ictrl.start = 1'b1;
          ictrl.mode  = IT_CORDIC;
          ictrl.steps = NW'(CORDIC_STEPS);
          icx         = {3'b0, hq, 16'b0};
          icy         = {{3{dz[16]}}, dz, 24'b0};
          state_next  = S_VA;
        end
      end
      S_VA:      if (idone) state_next = S_DIV_GO;
      S_DIV_GO: begin
        ictrl.start = 1'b1;
        ictrl.mode  = IT_DIV;
        ictrl.steps = RATIO_STEPS;
        inum        = pass ? RW'(mag_f) : RW'(mag_b);
        iden        = pass ? RW'({tf, 17'b0}) : RW'({lt, 9'b0});
        state_next  = S_DIV;
      end
      S_DIV:     if (idone) state_next = S_CC;
      S_CC: begin
        mul_a      = MW'(cmag);
        mul_b      = MW'(cmag);
        state_next = S_SQ_GO;
      end
      S_SQ_GO: begin
        ictrl.start = 1'b1;
        inum        = (RW'(1) << 60) - mul_p[RW-1:0];
        state_next  = S_SQ_S;
      end
      S_SQ_S: begin
        if (idone) begin
          ictrl.start = 1'b1;
          ictrl.mode  = IT_CORDIC;
          ictrl.steps = NW'(CORDIC_STEPS);
          icx         = CW'(cval);
          icy         = $signed(CW'(ires));
          state_next  = S_ACOS;
        end
      end
      S_ACOS: begin
        if (idone) state_next = pass ? S_CD_MUL : S_DIV_GO;
      end
      S_CD_MUL: begin
        mul_a      = MW'(rad_mag);
        mul_b      = MW'(CD_PER_RAD);
        state_next = S_CD_RND;
      end
      S_CD_RND:  state_next = (j == 2'd2) ? S_DIFF : S_CD_MUL;
      S_DIFF:    state_next = S_BIG;
      S_BIG:     state_next = S_SCALE;
      S_SCALE:   state_next = (big == '0) ? S_FAIL : S_SPD_MUL;
      S_SPD_MUL: begin
        mul_a      = MW'(dif[j]);
        mul_b      = MW'(spd);
        state_next = S_SPD_GO;
      end
      S_SPD_GO: begin
        ictrl.start = 1'b1;
        ictrl.mode  = IT_DIV;
        ictrl.steps = SPEED_STEPS;
        inum        = mul_p[RW-1:0];
        iden        = RW'({big, 16'b0});
        state_next  = S_SPD_DIV;
      end
      S_SPD_DIV: begin
        if (idone) state_next = (j == 2'd2) ? S_FAIL : S_SPD_MUL;
      end
      S_FAIL: begin
        if (m_tvalid && m_tready) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // S_FAIL doubles as the output state; ok_r tells a result from a failure.
  logic out_st;
  logic fail_go;
  logic done_spd;
  logic out_live;
  assign fail_go  = (state_next == S_FAIL) && (state != S_FAIL);
  assign done_spd = ((state == S_SCALE) && (big == '0)) ||
                    ((state == S_SPD_DIV) && idone && (j == 2'd2));
  assign out_st   = (state == S_FAIL) && out_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_live <= 1'b0;
    end else if (fail_go) begin
      out_live <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      out_live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          dx   <= 17'($signed(s_tdata[15:0])) - 17'(anchor_x);
          dy   <= 17'($signed(s_tdata[31:16])) - 17'(anchor_y);
          dz   <= 17'($signed(s_tdata[47:32])) - 17'(anchor_z);
          spd  <= s_tdata[63:48];
          ok_r <= 1'b0;
        end
      end
      S_SQ_DY:   sq0  <= mul_p[50:0];
      S_LEN:     if (idone) hq <= hq_d[26] ? 25'(-hq_d) : 25'(hq_d);
      S_SQ_ZQ:   sq0  <= mul_p[50:0];
      S_L2:      l2   <= l2_sum;
      S_LQ:      if (idone) lq <= ires[25:0];
      S_FF:      tt   <= mul_p[23:0];
      S_TF:      ff   <= mul_p[23:0];
      S_LT:      tf   <= mul_p[23:0];
      S_NUM: begin
        lt    <= mul_p[37:0];
        num_f <= $signed({11'b0, 25'(tt) + 25'(ff), 16'b0}) - $signed({1'b0, l2});
        num_b <= $signed({1'b0, l2}) +
                 ($signed({12'b0, tt, 16'b0}) - $signed({12'b0, ff, 16'b0}));
      end
      S_HIP:     if (idone) rad[0] <= iang;
      S_VA: begin
        if (idone) begin
          va   <= iang;
          pass <= 1'b0;
        end
      end
      S_DIV: begin
        if (idone) begin
          cmag <= ires;
          cneg <= pass ? num_f[51] : num_b[51];
        end
      end
      S_ACOS: begin
        if (idone) begin
          if (pass) begin
            rad[2] <= iang;
          end else begin
            rad[1] <= iang + va;
          end
          pass <= 1'b1;
          j    <= 2'd0;
        end
      end
      S_CD_RND: begin
        angv[j] <= cd_v[16:0];
        j       <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          dif[k] <= dd[k][17] ? 17'(-dd[k]) : 17'(dd[k]);
        end
      end
      S_BIG: begin
        big <= big_c;
        j   <= 2'd0;
      end
      S_SCALE: begin
        if (big == '0) begin
          for (int k = 0; k < 3; k++) begin
            speed[k] <= spd;
          end
        end
      end
      S_SPD_DIV: begin
        if (idone) begin
          speed[j] <= ires[15:0];
          j        <= j + 2'd1;
        end
      end
      default: ;
    endcase
    if (done_spd) ok_r <= 1'b1;
    if (fail_go && !done_spd && state != S_IDLE) begin
      for (int k = 0; k < 3; k++) begin
        angv[k]  <= '0;
        speed[k] <= '0;
      end
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_st;
  assign m_tuser   = ok_r;
  assign m_tdata   = {5'b0, speed[2], speed[1], speed[0], angv[2], angv[1], angv[0]};
  assign cfg_ready = 1'b1;

endmodule

/* hdl/lik_sva.sv */
// Port checker for the leg inverse kinematics unit, bound to the top level.
// Depends on lik_pkg.
module lik_sva (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [lik_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready after accepting a word");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("failure result carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind leg_inverse_kinematics_unit lik_sva u_lik_sva (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
